// File: hw/rtl/camera_pose_from_surface_normal_assert.svh
// ----------------------------------------------------------------------------
// Camera pose assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CAMERA_POSE_FROM_SURFACE_NORMAL_ASSERT_SVH
`define CAMERA_POSE_FROM_SURFACE_NORMAL_ASSERT_SVH

// Same-cycle implication
`define CPSN_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication
`define CPSN_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// File: hw/rtl/cpsn_pkg.sv
// ----------------------------------------------------------------------------
// Camera pose package
// Formats, pipeline stage numbers, shared types and helper functions.
// ----------------------------------------------------------------------------
package cpsn_pkg;

   // unit vector magnitudes are unsigned Q1.30
   localparam int UNIT_FRAC      = 30;
   localparam int ROT_FRAC_BITS  = 14;
   localparam int ROT_SHIFT      = UNIT_FRAC - ROT_FRAC_BITS;
   localparam int ROT_PROD_SHIFT = 2 * UNIT_FRAC - ROT_FRAC_BITS;

   // arithmetic unit depths
   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 31;

   // stage numbers along the main pipeline
   localparam int S_IN    = 1;
   localparam int S_MAX   = 2;
   localparam int S_SHIFT = 3;
   localparam int S_SQ    = 4;
   localparam int S_SUM   = 5;
   localparam int S_LEN   = S_SUM + SQRT_STAGES;
   localparam int S_NUM   = S_LEN + 1;
   localparam int S_QUO   = S_NUM + DIV_STAGES;
   localparam int S_UNIT  = S_QUO + 1;
   localparam int S_PROD  = S_UNIT + 1;
   localparam int S_OFF   = S_PROD + 1;
   localparam int S_SEL   = S_OFF + 1;
   localparam int S_CAM   = S_SEL + 1;
   localparam int S_ROOT  = S_OFF + SQRT_STAGES;
   localparam int S_SB    = S_ROOT + 1;
   localparam int S_RMUL  = S_SB + 1;
   localparam int S_OUT   = S_RMUL + 1;
   // first delay entry sits at S_CAM, last one must line up with S_ROOT
   localparam int CAM_DLY = S_ROOT - S_CAM + 1;

   // register reset values
   localparam logic [22:0]        STANDOFF_RESET = 23'd65536;
   localparam logic signed [23:0] FLOOR_RESET    = 24'sd32768;
   localparam logic [30:0]        UNIT_ONE       = 31'(1) << UNIT_FRAC;

   typedef enum logic {
      REG_STANDOFF = 1'b0,
      REG_FLOOR    = 1'b1
   } reg_index_type;

   // per-request data that rides alongside the arithmetic
   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic [2:0]         neg;    // sign bits of the normal
      logic               x_nz;   // normal x nonzero: yaw is defined
      logic               zero;   // zero-length normal
   } side_type;

   typedef struct packed {
      side_type         side;
      logic [2:0][31:0] m3;   // scaled normal magnitudes
      logic [1:0][31:0] m2;   // scaled planar magnitudes
   } norm_type;

   typedef struct packed {
      logic [30:0] ca_m;
      logic [30:0] sa_m;
      logic [30:0] cb_m;
      logic        ca_neg;
      logic        sa_neg;
      logic        cb_neg;
      logic        zero;
   } ang_type;

   typedef logic [2:0][31:0] cam_type;

   typedef struct packed {
      logic [63:0] x;
      logic [31:0] r;
      logic [33:0] rem;
   } sqrt_stage_type;

   typedef struct packed {
      logic [61:0] rem;
      logic [31:0] den;
      logic [30:0] q;
   } div_stage_type;

   // magnitude of a 32 bit two's complement value
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   // left shift that brings the leading one to bit 30
   function automatic logic [4:0] norm_shift(input logic [31:0] m);
      logic [4:0] sh;
      sh = '0;
      for (int b = 0; b < UNIT_FRAC; b++) begin
         if (m[b]) sh = 5'(UNIT_FRAC - b);
      end
      if (m[31] | m[30]) sh = '0;
      return sh;
   endfunction

   // apply a sign to a rotation magnitude
   function automatic logic signed [15:0] signed16(input logic [14:0] mag, input logic neg);
      return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

// File: hw/rtl/cpsn_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring square root, one root bit per stage, floor root and remainder.
// ----------------------------------------------------------------------------
module cpsn_sqrt
   import cpsn_pkg::*;
(
   input  logic        clock,
   input  logic [63:0] radicand,
   output logic [31:0] root,
   output logic [33:0] remainder
);

   sqrt_stage_type stage_ff [SQRT_STAGES];
   sqrt_stage_type stage_in [SQRT_STAGES];
   sqrt_stage_type first_src;

   // bring down two radicand bits and try the next root bit
   function automatic sqrt_stage_type sqrt_step(input sqrt_stage_type s);
      sqrt_stage_type o;
      logic [35:0]    cur;
      logic [35:0]    trial;
      logic           fit;
      cur   = {s.rem, s.x[63:62]};
      trial = {2'b00, s.r, 2'b01};
      fit   = cur >= trial;
      o.rem = fit ? 34'(cur - trial) : 34'(cur);
      o.r   = {s.r[30:0], fit};
      o.x   = {s.x[61:0], 2'b00};
      return o;
   endfunction

   assign first_src = '{x: radicand, r: '0, rem: '0};

   // one step per stage
   always_comb begin
      stage_in[0] = sqrt_step(first_src);
      for (int k = 1; k < SQRT_STAGES; k++) begin
         stage_in[k] = sqrt_step(stage_ff[k-1]);
      end
   end

   // advance every stage each cycle
   always_ff @(posedge clock) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
         stage_ff[k] <= stage_in[k];
      end
   end

   assign root      = stage_ff[SQRT_STAGES-1].r;
   assign remainder = stage_ff[SQRT_STAGES-1].rem;

endmodule

// File: hw/rtl/cpsn_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage; quotient below 2^31.
// ----------------------------------------------------------------------------
module cpsn_div
   import cpsn_pkg::*;
(
   input  logic        clock,
   input  logic [61:0] numer,
   input  logic [31:0] denom,
   output logic [30:0] quotient
);

   div_stage_type stage_ff [DIV_STAGES];
   div_stage_type stage_in [DIV_STAGES];
   div_stage_type first_src;

   // subtract the shifted divisor where it fits
   function automatic div_stage_type div_step(input div_stage_type s, input int sh);
      div_stage_type o;
      logic [62:0]   trial;
      logic          fit;
      trial = {31'b0, s.den} << sh;
      fit   = {1'b0, s.rem} >= trial;
      o.rem = fit ? 62'({1'b0, s.rem} - trial) : s.rem;
      o.den = s.den;
      o.q   = {s.q[29:0], fit};
      return o;
   endfunction

   assign first_src = '{rem: numer, den: denom, q: '0};

   // most significant quotient bit first
   always_comb begin
      stage_in[0] = div_step(first_src, DIV_STAGES - 1);
      for (int k = 1; k < DIV_STAGES; k++) begin
         stage_in[k] = div_step(stage_ff[k-1], DIV_STAGES - 1 - k);
      end
   end

   // advance every stage each cycle
   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         stage_ff[k] <= stage_in[k];
      end
   end

   assign quotient = stage_ff[DIV_STAGES-1].q;

endmodule

// File: hw/rtl/camera_pose_from_surface_normal.sv
// ----------------------------------------------------------------------------
// Camera pose from surface normal
// Zero-roll look-at pose and standoff position from a point and its normal.
// ----------------------------------------------------------------------------
// The block takes one request per clock and never raises busy. Each request
// gives one result on the rsp_ ports, marked by rsp_valid for one cycle. The
// pipeline runs through a 32-stage square root (normal length), a 31-stage
// divider (unit vector) and a second 32-stage square root (pitch sine), plus
// the scaling, offset and rotation product stages around them. The receiver
// cannot stall, so the pipeline advances every cycle. The user must write
// registers over the csr_ port only while no request is in flight; the block
// itself does not enforce this.
`include "camera_pose_from_surface_normal_assert.svh"

module camera_pose_from_surface_normal
   import cpsn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [31:0] req_normal_x,
   input  logic signed [31:0] req_normal_y,
   input  logic signed [31:0] req_normal_z,
   // result channel
   output logic               rsp_valid,
   output logic signed [15:0] rsp_rot_00,
   output logic signed [15:0] rsp_rot_01,
   output logic signed [15:0] rsp_rot_02,
   output logic signed [15:0] rsp_rot_10,
   output logic signed [15:0] rsp_rot_11,
   output logic signed [15:0] rsp_rot_12,
   output logic signed [15:0] rsp_rot_21,
   output logic signed [15:0] rsp_rot_22,
   output logic signed [31:0] rsp_cam_x,
   output logic signed [31:0] rsp_cam_y,
   output logic signed [31:0] rsp_cam_z,
   output logic               rsp_zero_normal,
   // configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [22:0]        dist_ff;
   logic signed [23:0] floor_ff;
   logic               csr_write;
   reg_index_type      csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   // write on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff  <= STANDOFF_RESET;
         floor_ff <= FLOOR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_STANDOFF: dist_ff  <= csr_pwdata[22:0];
            REG_FLOOR:    floor_ff <= $signed(csr_pwdata[23:0]);
            default: ;
         endcase
      end
   end

   // return the selected register
   always_comb begin
      case (csr_index)
         REG_STANDOFF: csr_prdata = {9'b0, dist_ff};
         REG_FLOOR:    csr_prdata = 32'(floor_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Valid line: one bit per stage, no stalls
   // ------------------------------------------------------------------
   logic [S_OUT:S_IN] vld_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[S_OUT-1:S_IN], start & ~busy};
      end
   end

   // ------------------------------------------------------------------
   // Input capture and magnitudes
   // ------------------------------------------------------------------
   side_type          s1_side_in, s1_side_ff;
   logic [2:0][31:0]  s1_mag_in, s1_mag_ff;

   always_comb begin
      s1_side_in.px   = req_point_x;
      s1_side_in.py   = req_point_y;
      s1_side_in.pz   = req_point_z;
      s1_side_in.neg  = {req_normal_z[31], req_normal_y[31], req_normal_x[31]};
      s1_side_in.x_nz = req_normal_x != '0;
      s1_side_in.zero = (req_normal_x == '0) && (req_normal_y == '0) &&
                        (req_normal_z == '0);
      s1_mag_in[0]    = mag32(req_normal_x);
      s1_mag_in[1]    = mag32(req_normal_y);
      s1_mag_in[2]    = mag32(req_normal_z);
   end

   always_ff @(posedge clock) begin
      s1_side_ff <= s1_side_in;
      s1_mag_ff  <= s1_mag_in;
   end

   // ------------------------------------------------------------------
   // Largest magnitude, then scale so it sits at bit 30
   // ------------------------------------------------------------------
   side_type         s2_side_ff;
   logic [2:0][31:0] s2_mag_ff;
   logic [31:0]      s2_max3_in, s2_max3_ff, s2_max2_in, s2_max2_ff;

   always_comb begin
      s2_max2_in = (s1_mag_ff[0] > s1_mag_ff[1]) ? s1_mag_ff[0] : s1_mag_ff[1];
      s2_max3_in = (s2_max2_in > s1_mag_ff[2]) ? s2_max2_in : s1_mag_ff[2];
   end

   always_ff @(posedge clock) begin
      s2_side_ff <= s1_side_ff;
      s2_mag_ff  <= s1_mag_ff;
      s2_max3_ff <= s2_max3_in;
      s2_max2_ff <= s2_max2_in;
   end

   norm_type   s3_norm_in, s3_norm_ff, s4_norm_ff, s5_norm_ff;
   logic [4:0] sh3, sh2;

   always_comb begin
      sh3 = norm_shift(s2_max3_ff);
      sh2 = norm_shift(s2_max2_ff);
      s3_norm_in.side = s2_side_ff;
      for (int i = 0; i < 3; i++) s3_norm_in.m3[i] = s2_mag_ff[i] << sh3;
      for (int i = 0; i < 2; i++) s3_norm_in.m2[i] = s2_mag_ff[i] << sh2;
   end

   // ------------------------------------------------------------------
   // Squares and sums of squares
   // ------------------------------------------------------------------
   logic [2:0][63:0] s4_sq3_in, s4_sq3_ff;
   logic [1:0][63:0] s4_sq2_in, s4_sq2_ff;
   logic [63:0]      s5_sum3_ff, s5_sum2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) s4_sq3_in[i] = s3_norm_ff.m3[i] * s3_norm_ff.m3[i];
      for (int i = 0; i < 2; i++) s4_sq2_in[i] = s3_norm_ff.m2[i] * s3_norm_ff.m2[i];
   end

   always_ff @(posedge clock) begin
      s3_norm_ff <= s3_norm_in;
      s4_norm_ff <= s3_norm_ff;
      s4_sq3_ff  <= s4_sq3_in;
      s4_sq2_ff  <= s4_sq2_in;
      s5_norm_ff <= s4_norm_ff;
      s5_sum3_ff <= s4_sq3_ff[0] + s4_sq3_ff[1] + s4_sq3_ff[2];
      s5_sum2_ff <= s4_sq2_ff[0] + s4_sq2_ff[1];
   end

   // ------------------------------------------------------------------
   // Vector lengths
   // ------------------------------------------------------------------
   logic [31:0] len3, len2;
   norm_type    norm_dly_ff [SQRT_STAGES];

   cpsn_sqrt u_len3_sqrt (
      .clock     (clock),
      .radicand  (s5_sum3_ff),
      .root      (len3),
      .remainder ()
   );

   cpsn_sqrt u_len2_sqrt (
      .clock     (clock),
      .radicand  (s5_sum2_ff),
      .root      (len2),
      .remainder ()
   );

   // hold the scaled magnitudes beside the square roots
   always_ff @(posedge clock) begin
      norm_dly_ff[0] <= s5_norm_ff;
      for (int k = 1; k < SQRT_STAGES; k++) norm_dly_ff[k] <= norm_dly_ff[k-1];
   end

   // ------------------------------------------------------------------
   // Division operands: (m << 30) + len/2 over len
   // ------------------------------------------------------------------
   norm_type         len_norm;
   side_type         num_side_ff;
   logic [2:0][61:0] num3_in, num3_ff;
   logic [1:0][61:0] num2_in, num2_ff;
   logic [31:0]      den3_ff, den2_ff;

   assign len_norm = norm_dly_ff[SQRT_STAGES-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num3_in[i] = {len_norm.m3[i], 30'b0} + 62'(len3[31:1]);
      end
      for (int i = 0; i < 2; i++) begin
         num2_in[i] = {len_norm.m2[i], 30'b0} + 62'(len2[31:1]);
      end
   end

   always_ff @(posedge clock) begin
      num_side_ff <= len_norm.side;
      num3_ff     <= num3_in;
      num2_ff     <= num2_in;
      den3_ff     <= len3;
      den2_ff     <= len2;
   end

   logic [2:0][30:0] q3;
   logic [1:0][30:0] q2;
   side_type         side_dly_ff [DIV_STAGES];

   for (genvar g = 0; g < 3; g++) begin : g_unit3
      cpsn_div u_div (
         .clock    (clock),
         .numer    (num3_ff[g]),
         .denom    (den3_ff),
         .quotient (q3[g])
      );
   end

   for (genvar g = 0; g < 2; g++) begin : g_unit2
      cpsn_div u_div (
         .clock    (clock),
         .numer    (num2_ff[g]),
         .denom    (den2_ff),
         .quotient (q2[g])
      );
   end

   // hold the point and flags beside the dividers
   always_ff @(posedge clock) begin
      side_dly_ff[0] <= num_side_ff;
      for (int k = 1; k < DIV_STAGES; k++) side_dly_ff[k] <= side_dly_ff[k-1];
   end

   // ------------------------------------------------------------------
   // Unit normal and yaw terms
   // ------------------------------------------------------------------
   side_type         quo_side;
   side_type         unit_side_ff;
   logic [2:0][30:0] nq_in, nq_ff;
   ang_type          unit_ang_in, unit_ang_ff;

   assign quo_side = side_dly_ff[DIV_STAGES-1];

   always_comb begin
      for (int i = 0; i < 3; i++) nq_in[i] = quo_side.zero ? '0 : q3[i];
      unit_ang_in.ca_m   = quo_side.x_nz ? q2[0] : UNIT_ONE;
      unit_ang_in.sa_m   = quo_side.x_nz ? q2[1] : '0;
      unit_ang_in.cb_m   = nq_in[2];
      // view direction is the negated normal
      unit_ang_in.ca_neg = quo_side.x_nz & ~quo_side.neg[0];
      unit_ang_in.sa_neg = quo_side.x_nz & ~quo_side.neg[1];
      unit_ang_in.cb_neg = ~quo_side.neg[2];
      unit_ang_in.zero   = quo_side.zero;
   end

   always_ff @(posedge clock) begin
      unit_side_ff <= quo_side;
      nq_ff        <= nq_in;
      unit_ang_ff  <= unit_ang_in;
   end

   // ------------------------------------------------------------------
   // Offset products and pitch cosine square
   // ------------------------------------------------------------------
   side_type         prod_side_ff;
   ang_type          prod_ang_ff;
   logic [2:0][53:0] off_prod_in, off_prod_ff;
   logic [61:0]      cbsq_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) off_prod_in[i] = 54'(dist_ff) * 54'(nq_ff[i]);
   end

   always_ff @(posedge clock) begin
      prod_side_ff <= unit_side_ff;
      prod_ang_ff  <= unit_ang_ff;
      off_prod_ff  <= off_prod_in;
      cbsq_ff      <= unit_ang_ff.cb_m * unit_ang_ff.cb_m;
   end

   // ------------------------------------------------------------------
   // Rounded offsets at full and half distance; pitch radicand
   // ------------------------------------------------------------------
   side_type           off_side_ff;
   ang_type            off_ang_ff;
   logic signed [23:0] off30_in [3], off30_ff [3];
   logic signed [23:0] off31_in [3], off31_ff [3];
   logic [53:0]        rnd30, rnd31;
   logic [63:0]        pitch_x_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd30 = off_prod_ff[i] + (54'(1) << (UNIT_FRAC - 1));
         rnd31 = off_prod_ff[i] + (54'(1) << UNIT_FRAC);
         off30_in[i] = prod_side_ff.neg[i] ? -$signed({1'b0, rnd30[52:30]})
                                           :  $signed({1'b0, rnd30[52:30]});
         off31_in[i] = prod_side_ff.neg[i] ? -$signed({1'b0, rnd31[53:31]})
                                           :  $signed({1'b0, rnd31[53:31]});
      end
   end

   always_ff @(posedge clock) begin
      off_side_ff <= prod_side_ff;
      off_ang_ff  <= prod_ang_ff;
      off30_ff    <= off30_in;
      off31_ff    <= off31_in;
      pitch_x_ff  <= (64'(1) << (2 * UNIT_FRAC)) - 64'(cbsq_ff);
   end

   // ------------------------------------------------------------------
   // Floor test, then saturated camera position
   // ------------------------------------------------------------------
   logic signed [33:0] z_sum;
   logic               half;
   side_type           sel_side_ff;
   logic signed [23:0] off_sel_ff [3];
   logic signed [32:0] cam_sum [3];
   cam_type            cam_in;
   cam_type            cam_dly_ff [CAM_DLY];

   always_comb begin
      z_sum = 34'(off_side_ff.pz) + 34'(off30_ff[2]);
      half  = z_sum < 34'(floor_ff);
   end

   always_ff @(posedge clock) begin
      sel_side_ff <= off_side_ff;
      for (int i = 0; i < 3; i++) off_sel_ff[i] <= half ? off31_ff[i] : off30_ff[i];
   end

   // add and clamp to the 32 bit range
   always_comb begin
      cam_sum[0] = 33'(sel_side_ff.px) + 33'(off_sel_ff[0]);
      cam_sum[1] = 33'(sel_side_ff.py) + 33'(off_sel_ff[1]);
      cam_sum[2] = 33'(sel_side_ff.pz) + 33'(off_sel_ff[2]);
      for (int i = 0; i < 3; i++) begin
         if (cam_sum[i][32] != cam_sum[i][31]) begin
            cam_in[i] = cam_sum[i][32] ? 32'h8000_0000 : 32'h7fff_ffff;
         end else begin
            cam_in[i] = cam_sum[i][31:0];
         end
      end
   end

   // hold the position until the pitch sine is ready
   always_ff @(posedge clock) begin
      cam_dly_ff[0] <= cam_in;
      for (int k = 1; k < CAM_DLY; k++) cam_dly_ff[k] <= cam_dly_ff[k-1];
   end

   // ------------------------------------------------------------------
   // Pitch sine: rounded square root of 1 - cos^2
   // ------------------------------------------------------------------
   logic [31:0] sb_root;
   logic [33:0] sb_rem;
   ang_type     ang_dly_ff [SQRT_STAGES];

   cpsn_sqrt u_pitch_sqrt (
      .clock     (clock),
      .radicand  (pitch_x_ff),
      .root      (sb_root),
      .remainder (sb_rem)
   );

   always_ff @(posedge clock) begin
      ang_dly_ff[0] <= off_ang_ff;
      for (int k = 1; k < SQRT_STAGES; k++) ang_dly_ff[k] <= ang_dly_ff[k-1];
   end

   ang_type     sb_ang_ff;
   cam_type     sb_cam_ff;
   logic [30:0] sb_in, sb_ff;

   // round up where the remainder exceeds the root
   assign sb_in = sb_root[30:0] + 31'(sb_rem > 34'(sb_root));

   always_ff @(posedge clock) begin
      sb_ang_ff <= ang_dly_ff[SQRT_STAGES-1];
      sb_cam_ff <= cam_dly_ff[CAM_DLY-1];
      sb_ff     <= sb_in;
   end

   // ------------------------------------------------------------------
   // Rotation products
   // ------------------------------------------------------------------
   ang_type     rm_ang_ff;
   cam_type     rm_cam_ff;
   logic [30:0] rm_sb_ff;
   logic [61:0] p_cc_ff, p_cs_ff, p_sc_ff, p_ss_ff;

   always_ff @(posedge clock) begin
      rm_ang_ff <= sb_ang_ff;
      rm_cam_ff <= sb_cam_ff;
      rm_sb_ff  <= sb_ff;
      p_cc_ff   <= sb_ang_ff.ca_m * sb_ang_ff.cb_m;
      p_cs_ff   <= sb_ang_ff.ca_m * sb_ff;
      p_sc_ff   <= sb_ang_ff.sa_m * sb_ang_ff.cb_m;
      p_ss_ff   <= sb_ang_ff.sa_m * sb_ff;
   end

   // ------------------------------------------------------------------
   // Round to the output format and register the result
   // ------------------------------------------------------------------
   function automatic logic [14:0] rnd_prod(input logic [61:0] p);
      logic [61:0] t;
      t = p + (62'(1) << (ROT_PROD_SHIFT - 1));
      return t[ROT_PROD_SHIFT +: 15];
   endfunction

   function automatic logic [14:0] rnd_unit(input logic [30:0] v);
      logic [30:0] t;
      t = v + (31'(1) << (ROT_SHIFT - 1));
      return t[ROT_SHIFT +: 15];
   endfunction

   logic signed [15:0] rot_in [8];
   logic signed [15:0] rot_ff [8];
   cam_type            out_cam_ff;
   logic               out_zero_ff;

   always_comb begin
      rot_in[0] = signed16(rnd_unit(rm_ang_ff.sa_m), rm_ang_ff.sa_neg);
      rot_in[1] = signed16(rnd_prod(p_cc_ff), rm_ang_ff.ca_neg ^ rm_ang_ff.cb_neg);
      rot_in[2] = signed16(rnd_prod(p_cs_ff), rm_ang_ff.ca_neg);
      rot_in[3] = signed16(rnd_unit(rm_ang_ff.ca_m), ~rm_ang_ff.ca_neg);
      rot_in[4] = signed16(rnd_prod(p_sc_ff), rm_ang_ff.sa_neg ^ rm_ang_ff.cb_neg);
      rot_in[5] = signed16(rnd_prod(p_ss_ff), rm_ang_ff.sa_neg);
      rot_in[6] = signed16(rnd_unit(rm_sb_ff), 1'b1);
      rot_in[7] = signed16(rnd_unit(rm_ang_ff.cb_m), rm_ang_ff.cb_neg);
   end

   always_ff @(posedge clock) begin
      rot_ff      <= rot_in;
      out_cam_ff  <= rm_cam_ff;
      out_zero_ff <= rm_ang_ff.zero;
   end

   assign rsp_valid       = vld_ff[S_OUT];
   assign rsp_rot_00      = rot_ff[0];
   assign rsp_rot_01      = rot_ff[1];
   assign rsp_rot_02      = rot_ff[2];
   assign rsp_rot_10      = rot_ff[3];
   assign rsp_rot_11      = rot_ff[4];
   assign rsp_rot_12      = rot_ff[5];
   assign rsp_rot_21      = rot_ff[6];
   assign rsp_rot_22      = rot_ff[7];
   assign rsp_cam_x       = $signed(out_cam_ff[0]);
   assign rsp_cam_y       = $signed(out_cam_ff[1]);
   assign rsp_cam_z       = $signed(out_cam_ff[2]);
   assign rsp_zero_normal = out_zero_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `CPSN_ASSERT_NOW(a_unit_range, vld_ff[S_UNIT],
      (nq_ff[0] <= UNIT_ONE) && (nq_ff[1] <= UNIT_ONE) && (nq_ff[2] <= UNIT_ONE) &&
      (unit_ang_ff.ca_m <= UNIT_ONE) && (unit_ang_ff.sa_m <= UNIT_ONE),
      "unit vector component above one")
   `CPSN_ASSERT_NEXT(a_pitch_sine_range, vld_ff[S_ROOT], sb_ff <= UNIT_ONE,
      "pitch sine above one")
   `CPSN_ASSERT_NOW(a_zero_normal_pose, rsp_valid && rsp_zero_normal,
      (rsp_rot_22 == 16'sd0) && (rsp_rot_21 == -16'sd16384) &&
      (rsp_rot_01 == 16'sd0) && (rsp_rot_11 == 16'sd0),
      "zero normal gives a wrong pitch")

endmodule
